>>> hw/rtl/alht_pkg.sv
`default_nettype none
package alht_pkg;

  // Default sizing for the top level
  localparam int AGENTS_DEF    = 16;
  localparam int TIME_BITS_DEF = 40;

  // The agent index field is fixed at four bits, so at most 16 entries are reachable
  localparam int ID_BITS  = 4;
  localparam int ID_SPAN  = 1 << ID_BITS;

  // APB register map
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [1:0] REG_DEGRADED   = 2'd0;
  localparam logic [1:0] REG_DISCONNECT = 2'd1;
  localparam logic [1:0] REG_DECAY      = 2'd2;

  localparam logic [19:0] DEGRADED_RST   = 20'd500;
  localparam logic [19:0] DISCONNECT_RST = 20'd2000;
  localparam logic [15:0] DECAY_RST      = 16'd58982;

  // Weight constants, Q1.15
  localparam logic [15:0] W_ONE   = 16'd32768;
  localparam logic [15:0] W_FLOOR = 16'd3276;
  localparam logic [15:0] MISSED_MAX = 16'hFFFF;

  // Age below this refreshes the stored time
  localparam int FRESH_MS = 10;

  // floor(x / 10) == (x * DIV10_MULT) >> DIV10_SHIFT for x below 699050
  localparam int          DIV10_IN_BITS = 19;
  localparam int          DIV10_SHIFT   = 22;
  localparam logic [18:0] DIV10_MULT    = 19'd419431;

  typedef enum logic [1:0] {
    OP_UPDATE    = 2'd0,
    OP_RECONNECT = 2'd1,
    OP_QUERY     = 2'd2,
    OP_SPARE     = 2'd3
  } alht_op_e;

  typedef enum logic [1:0] {
    LS_CONNECTED    = 2'd0,
    LS_DEGRADED     = 2'd1,
    LS_DISCONNECTED = 2'd2
  } alht_link_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } alht_state_e;

  typedef struct packed {
    logic [19:0] degraded_ms;
    logic [19:0] disconnect_ms;
    logic [15:0] decay;
  } alht_cfg_t;

  // Table entry without its timestamp (timestamp width is a parameter)
  typedef struct packed {
    alht_link_e  link;
    logic [15:0] weight;
    logic [15:0] missed;
  } alht_ent_t;

  localparam int ENT_BITS = $bits(alht_ent_t);

  typedef struct packed {
    alht_ent_t ent;
    logic      known;
    logic      added;
  } alht_res_t;

endpackage
`default_nettype wire

>>> hw/rtl/alht_ram.sv
`default_nettype none
module alht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/alht_cfg.sv
`default_nettype none
module alht_cfg
  import alht_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output logic      [CFG_DATA_BITS-1:0] prdata,
  output alht_cfg_t                     cfg_o
);

  alht_cfg_t   cfg_q, cfg_d;
  logic [1:0]  reg_idx;
  logic        wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_DEGRADED:   cfg_d.degraded_ms   = pwdata[19:0];
        REG_DISCONNECT: cfg_d.disconnect_ms = pwdata[19:0];
        REG_DECAY:      cfg_d.decay         = pwdata[15:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.degraded_ms   <= DEGRADED_RST;
      cfg_q.disconnect_ms <= DISCONNECT_RST;
      cfg_q.decay         <= DECAY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEGRADED:   prdata = {12'd0, cfg_q.degraded_ms};
      REG_DISCONNECT: prdata = {12'd0, cfg_q.disconnect_ms};
      REG_DECAY:      prdata = {16'd0, cfg_q.decay};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> hw/rtl/alht_update.sv
`default_nettype none
module alht_update
  import alht_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire alht_op_e              op_i,
  input  wire logic                  in_table_i,
  input  wire logic                  valid_i,
  input  wire alht_ent_t             ent_i,
  input  wire logic [TIME_BITS-1:0]  last_i,
  input  wire logic [TIME_BITS-1:0]  now_i,
  input  wire alht_cfg_t             cfg_i,
  output logic                       wr_en_o,
  output alht_ent_t                  wr_ent_o,
  output logic      [TIME_BITS-1:0]  wr_time_o,
  output alht_res_t                  res_o
);

  // Wide enough for both the timestamps and the 20-bit thresholds, plus sign
  localparam int AGE_W = ((TIME_BITS > 20) ? TIME_BITS : 20) + 2;

  logic signed [AGE_W-1:0]           age;
  logic                              fresh, is_conn, is_degr;
  logic [DIV10_IN_BITS-1:0]          w_x11;
  logic [2*DIV10_IN_BITS-1:0]        grow_prod;
  logic [15:0]                       w_grow, w_grow_cap;
  logic [31:0]                       decay_prod;
  logic [15:0]                       w_decay, w_decay_flr;
  logic [15:0]                       missed_inc;
  alht_ent_t                         upd_ent;
  alht_ent_t                         fresh_ent;

  // Signed age, no wrap: both operands zero-extended
  assign age     = $signed(AGE_W'(now_i) - AGE_W'(last_i));
  assign fresh   = age < $signed(AGE_W'(FRESH_MS));
  assign is_conn = age < $signed(AGE_W'(cfg_i.degraded_ms));
  assign is_degr = age < $signed(AGE_W'(cfg_i.disconnect_ms));

  // Growth by 1.1: weight*11 by shift-add, then divide by ten by reciprocal
  assign w_x11 = DIV10_IN_BITS'({ent_i.weight, 3'b000})
               + DIV10_IN_BITS'({ent_i.weight, 1'b0})
               + DIV10_IN_BITS'(ent_i.weight);
  assign grow_prod  = (2*DIV10_IN_BITS)'(w_x11) * (2*DIV10_IN_BITS)'(DIV10_MULT);
  assign w_grow     = grow_prod[DIV10_SHIFT+15:DIV10_SHIFT];
  assign w_grow_cap = (w_grow > W_ONE) ? W_ONE : w_grow;

  // Decay: Q0.16 multiply, floored at 0.1
  assign decay_prod  = 32'(ent_i.weight) * 32'(cfg_i.decay);
  assign w_decay     = decay_prod[31:16];
  assign w_decay_flr = (w_decay < W_FLOOR) ? W_FLOOR : w_decay;

  assign missed_inc = (ent_i.missed == MISSED_MAX) ? ent_i.missed : ent_i.missed + 16'd1;

  assign fresh_ent = '{link: LS_CONNECTED, weight: W_ONE, missed: 16'd0};

  always_comb begin
    if (is_conn) begin
      upd_ent = '{link: LS_CONNECTED, weight: w_grow_cap, missed: 16'd0};
    end else if (is_degr) begin
      upd_ent = '{link: LS_DEGRADED, weight: w_decay_flr, missed: missed_inc};
    end else begin
      upd_ent = '{link: LS_DISCONNECTED, weight: 16'd0, missed: ent_i.missed};
    end
  end

  always_comb begin
    wr_en_o   = 1'b0;
    wr_ent_o  = ent_i;
    wr_time_o = last_i;
    res_o     = '{ent: '{link: LS_DISCONNECTED, weight: W_ONE, missed: 16'd0},
                  known: 1'b0, added: 1'b0};
    if (in_table_i) begin
      unique case (op_i)
        OP_UPDATE: begin
          wr_en_o = 1'b1;
          if (!valid_i) begin
            wr_ent_o  = fresh_ent;
            wr_time_o = now_i;
          end else begin
            wr_ent_o  = upd_ent;
            wr_time_o = fresh ? now_i : last_i;
          end
        end
        OP_RECONNECT: begin
          wr_en_o   = valid_i;
          wr_ent_o  = fresh_ent;
          wr_time_o = now_i;
        end
        default: begin
          wr_en_o = 1'b0;
        end
      endcase
      if (valid_i || wr_en_o) begin
        res_o.ent   = wr_en_o ? wr_ent_o : ent_i;
        res_o.known = 1'b1;
        res_o.added = wr_en_o && !valid_i;
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/agent_link_health_table_core.sv
`default_nettype none
// Channel   | Handshake                  | Payload
// ----------+----------------------------+------------------------------------------
// command   | start / busy               | opcode_i, agent_sel_i, now_ms_i
// result    | result_valid_o (strobe)    | link_state_o, weight_o, missed_count_o,
//           |                            | known_o, newly_added_o
// config    | APB psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//
// On acceptance the table read is issued to the registered entry RAM; in the
// execute state the modified entry is written back and the result registered.
// No new command is accepted before the last is written back: busy is high for
// the write-back cycle, so a read never overlaps a pending write.
// The result strobe is high for one cycle after the write-back; the receiver
// cannot stall it, and the next command may be accepted in that same cycle.
// Reset clears the valid bits and restores register defaults; no clearing pass.
module agent_link_health_table_core
  import alht_pkg::*;
#(
  parameter int AGENTS    = AGENTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // command
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               opcode_i,
  input  wire logic [ID_BITS-1:0]       agent_sel_i,
  input  wire logic [TIME_BITS-1:0]     now_ms_i,
  // result
  output logic                          result_valid_o,
  output logic      [1:0]               link_state_o,
  output logic      [15:0]              weight_o,
  output logic      [15:0]              missed_count_o,
  output logic                          known_o,
  output logic                          newly_added_o,
  // config
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] paddr,
  input  wire logic [CFG_DATA_BITS-1:0] pwdata,
  output logic      [CFG_DATA_BITS-1:0] prdata,
  output logic                          pready
);

  // Only entries reachable by the 4-bit agent id get storage
  localparam int DEPTH  = (AGENTS < ID_SPAN) ? AGENTS : ID_SPAN;
  localparam int AW     = $clog2(DEPTH);
  localparam int WORD_W = ENT_BITS + TIME_BITS;

  alht_state_e            state_q, state_d;
  alht_op_e               op_q;
  logic                   in_tab_q;
  logic [AW-1:0]          idx_q;
  logic [TIME_BITS-1:0]   now_q;
  logic [DEPTH-1:0]       vld_q, vld_d;
  alht_res_t              res_q;
  logic                   res_vld_q, res_vld_d;

  logic                   accept;
  logic [31:0]            id_ext;
  logic [AW-1:0]          id_idx;
  logic                   id_in_tab;

  alht_cfg_t              cfg;
  logic [WORD_W-1:0]      rd_word, wr_word;
  alht_ent_t              rd_ent;
  logic [TIME_BITS-1:0]   rd_time;
  logic                   wr_en, do_wr;
  alht_ent_t              wr_ent;
  logic [TIME_BITS-1:0]   wr_time;
  alht_res_t              res_d;

  assign pready = 1'b1;

  alht_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  // Decode the agent id against the table size
  assign id_ext    = 32'(agent_sel_i);
  assign id_idx    = id_ext[AW-1:0];
  assign id_in_tab = id_ext < 32'(DEPTH);

  assign busy   = (state_q == S_EXEC);
  assign accept = start && !busy;

  // Hold the command for the write-back cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= alht_op_e'(opcode_i);
      in_tab_q <= id_in_tab;
      idx_q    <= id_idx;
      now_q    <= now_ms_i;
    end
  end

  // Entry RAM: word is {entry, timestamp}; contents only meaningful where valid
  alht_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_wr),
    .waddr_i (idx_q),
    .wdata_i (wr_word),
    .re_i    (accept),
    .raddr_i (id_idx),
    .rdata_o (rd_word)
  );

  assign rd_ent  = alht_ent_t'(rd_word[WORD_W-1:TIME_BITS]);
  assign rd_time = rd_word[TIME_BITS-1:0];
  assign wr_word = {wr_ent, wr_time};

  alht_update #(
    .TIME_BITS (TIME_BITS)
  ) u_update (
    .op_i       (op_q),
    .in_table_i (in_tab_q),
    .valid_i    (vld_q[idx_q]),
    .ent_i      (rd_ent),
    .last_i     (rd_time),
    .now_i      (now_q),
    .cfg_i      (cfg),
    .wr_en_o    (wr_en),
    .wr_ent_o   (wr_ent),
    .wr_time_o  (wr_time),
    .res_o      (res_d)
  );

  // Write back only during the execute cycle
  assign do_wr = busy && wr_en;

  always_comb begin
    state_d   = state_q;
    vld_d     = vld_q;
    res_vld_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        // Mark the entry valid on write-back, raise the result strobe
        if (wr_en) begin
          vld_d[idx_q] = 1'b1;
        end
        res_vld_d = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      vld_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      vld_q     <= vld_d;
      res_vld_q <= res_vld_d;
    end
  end

  // Register the result at the end of the execute cycle
  always_ff @(posedge clk_i) begin
    if (busy) begin
      res_q <= res_d;
    end
  end

  assign result_valid_o = res_vld_q;
  assign link_state_o   = res_q.ent.link;
  assign weight_o       = res_q.ent.weight;
  assign missed_count_o = res_q.ent.missed;
  assign known_o        = res_q.known;
  assign newly_added_o  = res_q.added;

endmodule
`default_nettype wire
